### rtl/jmp_pkg.sv
// Shared types and constants for the JPEG marker/segment parser.
// No dependencies; used by jmp_front, jmp_back and the top module under rtl/.
package jmp_pkg;

    localparam logic [7:0] CODE_SOI = 8'hD8;
    localparam logic [7:0] CODE_EOI = 8'hD9;
    localparam logic [7:0] CODE_SOS = 8'hDA;
    localparam logic [7:0] CODE_DQT = 8'hDB;
    localparam logic [7:0] CODE_DHT = 8'hC4;
    localparam logic [7:0] BYTE_PREFIX = 8'hFF;
    localparam logic [7:0] BYTE_STUFF = 8'h00;
    localparam logic [3:0] DHT_CLASS_MAX = 4'd3;
    localparam logic [15:0] LEN_HDR = 16'd2;
    localparam logic [15:0] DQT_LAST_OFF = 16'd64;
    localparam logic [15:0] DHT_COUNT_LAST = 16'd16;
    localparam logic [16:0] DHT_FIXED = 17'd17;
    localparam logic [16:0] SOS_FIXED = 17'd4;

    typedef enum logic [2:0] {
        MODE_PREFIX,
        MODE_CODE,
        MODE_LENHI,
        MODE_LENLO,
        MODE_PAYLOAD,
        MODE_SCAN,
        MODE_SCANFF
    } mode_t;

    typedef enum logic [1:0] {
        KIND_MARKER,
        KIND_PAYLOAD,
        KIND_ENTROPY,
        KIND_STRAY
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_LEN_SHORT,
        ERR_DHT_CLASS,
        ERR_LEN_MISMATCH
    } err_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       new_file;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  marker_code;
        logic [15:0] payload_offset;
        logic [7:0]  byte_value;
        logic        segment_last;
        err_t        error_code;
    } out_item_t;

    // Byte as classified by the front end
    typedef struct packed {
        logic [7:0] byte_val;
        logic       new_file;
        logic       is_prefix;   // 0xFF
        logic       is_stuff;    // 0x00
        logic       is_nolen;    // SOI or EOI
        logic       below_two;   // value 0 or 1 (low length byte check)
        logic       class_bad;   // high nibble above 3 (DHT class check)
    } tok_t;

endpackage

### rtl/jmp_fifo.sv
// Small first-word-fall-through queue built from registers.
// Depends on nothing; element type and depth come from the instantiating module.
module jmp_fifo #(
    parameter type T = logic,
    parameter int DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    output logic full,
    input  logic pop,
    output T     rdata,
    output logic empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/jmp_front.sv
// Front end: takes input bytes, classifies them and queues them for the parser.
// Depends on jmp_pkg and jmp_fifo.
module jmp_front
    import jmp_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t item,
    output logic     full,
    output tok_t     tok,
    output logic     tok_empty,
    input  logic     tok_take
);
    tok_t cls;

    always_comb
    begin
        cls.byte_val  = item.byte_in;
        cls.new_file  = item.new_file;
        cls.is_prefix = (item.byte_in == BYTE_PREFIX);
        cls.is_stuff  = (item.byte_in == BYTE_STUFF);
        cls.is_nolen  = (item.byte_in == CODE_SOI) || (item.byte_in == CODE_EOI);
        cls.below_two = (item.byte_in[7:1] == 7'd0);
        cls.class_bad = (item.byte_in[7:4] > DHT_CLASS_MAX);
    end

    jmp_fifo #(
        .T     (tok_t),
        .DEPTH (DEPTH)
    ) u_tok_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cls),
        .full  (full),
        .pop   (tok_take),
        .rdata (tok),
        .empty (tok_empty)
    );

endmodule

### rtl/jmp_back.sv
// Back end: marker/segment state machine, one classified byte per cycle while the result queue has room.
// Depends on jmp_pkg; fed by jmp_front, drains into the result queue.
module jmp_back
    import jmp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tok_t      tok,
    input  logic      tok_empty,
    output logic      tok_take,
    input  logic      res_full,
    output logic      res_push,
    output out_item_t res
);
    mode_t       mode_reg, mode_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] offset_reg, offset_next;
    logic [11:0] hsum_reg, hsum_next;
    logic [7:0]  ncomp_reg, ncomp_next;
    logic        halted_reg, halted_next;

    assign tok_take = !tok_empty && !res_full;

    always_comb
    begin
        mode_t       c_mode;
        logic [7:0]  c_code;
        logic [7:0]  c_len_hi;
        logic [15:0] c_remain;
        logic [15:0] c_offset;
        logic [11:0] c_hsum;
        logic [7:0]  c_ncomp;
        logic        c_halted;
        logic        emit;
        logic        last;
        logic [7:0]  b;
        logic [15:0] len;

        // new_file puts everything back to reset before this byte
        if (tok.new_file)
        begin
            c_mode   = MODE_PREFIX;
            c_code   = '0;
            c_len_hi = '0;
            c_remain = '0;
            c_offset = '0;
            c_hsum   = '0;
            c_ncomp  = '0;
            c_halted = 1'b0;
        end
        else
        begin
            c_mode   = mode_reg;
            c_code   = code_reg;
            c_len_hi = len_hi_reg;
            c_remain = remain_reg;
            c_offset = offset_reg;
            c_hsum   = hsum_reg;
            c_ncomp  = ncomp_reg;
            c_halted = halted_reg;
        end

        b    = tok.byte_val;
        len  = {c_len_hi, b};
        last = (c_remain == 16'd1);
        emit = 1'b0;

        mode_next   = c_mode;
        code_next   = c_code;
        len_hi_next = c_len_hi;
        remain_next = c_remain;
        offset_next = c_offset;
        hsum_next   = c_hsum;
        ncomp_next  = c_ncomp;
        halted_next = c_halted;

        res.kind           = KIND_MARKER;
        res.marker_code    = c_code;
        res.payload_offset = '0;
        res.byte_value     = b;
        res.segment_last   = 1'b0;
        res.error_code     = ERR_NONE;

        if (!c_halted)
        begin
            unique case (c_mode)
                MODE_PREFIX:
                begin
                    if (tok.is_prefix)
                    begin
                        mode_next = MODE_CODE;
                    end
                    else
                    begin
                        emit     = 1'b1;
                        res.kind = KIND_STRAY;
                    end
                end
                MODE_LENHI:
                begin
                    len_hi_next = b;
                    mode_next   = MODE_LENLO;
                end
                MODE_LENLO:
                begin
                    res.kind         = KIND_PAYLOAD;
                    res.segment_last = 1'b1;
                    if ((c_len_hi == '0) && tok.below_two)
                    begin
                        emit           = 1'b1;
                        res.error_code = ERR_LEN_SHORT;
                        halted_next    = 1'b1;
                    end
                    else
                    begin
                        remain_next = len - LEN_HDR;
                        offset_next = '0;
                        hsum_next   = '0;
                        ncomp_next  = '0;
                        if (len == LEN_HDR)
                        begin
                            mode_next = (c_code == CODE_SOS) ? MODE_SCAN : MODE_PREFIX;
                            if ((c_code == CODE_DQT) || (c_code == CODE_DHT) ||
                                (c_code == CODE_SOS))
                            begin
                                emit           = 1'b1;
                                res.error_code = ERR_LEN_MISMATCH;
                            end
                        end
                        else
                        begin
                            mode_next = MODE_PAYLOAD;
                        end
                    end
                end
                MODE_PAYLOAD:
                begin
                    emit               = 1'b1;
                    res.kind           = KIND_PAYLOAD;
                    res.payload_offset = c_offset;
                    res.segment_last   = last;
                    if (c_code == CODE_DHT)
                    begin
                        if ((c_offset == '0) && tok.class_bad)
                        begin
                            res.error_code = ERR_DHT_CLASS;
                            halted_next    = 1'b1;
                        end
                        else if ((c_offset != '0) && (c_offset <= DHT_COUNT_LAST))
                        begin
                            hsum_next = c_hsum + 12'(b);
                        end
                    end
                    else if ((c_code == CODE_SOS) && (c_offset == '0))
                    begin
                        ncomp_next = b;
                    end
                    if (last && (res.error_code == ERR_NONE))
                    begin
                        if (c_code == CODE_DQT)
                        begin
                            if (c_offset != DQT_LAST_OFF)
                            begin
                                res.error_code = ERR_LEN_MISMATCH;
                            end
                        end
                        else if (c_code == CODE_DHT)
                        begin
                            if ((c_offset < DHT_COUNT_LAST) ||
                                ((17'(c_offset) + 17'd1) != (DHT_FIXED + 17'(hsum_next))))
                            begin
                                res.error_code = ERR_LEN_MISMATCH;
                            end
                        end
                        else if (c_code == CODE_SOS)
                        begin
                            if ((17'(c_offset) + 17'd1) !=
                                (SOS_FIXED + 17'({ncomp_next, 1'b0})))
                            begin
                                res.error_code = ERR_LEN_MISMATCH;
                            end
                        end
                    end
                    remain_next = c_remain - 16'd1;
                    offset_next = c_offset + 16'd1;
                    if (last && !halted_next)
                    begin
                        mode_next = (c_code == CODE_SOS) ? MODE_SCAN : MODE_PREFIX;
                    end
                end
                MODE_SCAN:
                begin
                    if (tok.is_prefix)
                    begin
                        mode_next = MODE_SCANFF;
                    end
                    else
                    begin
                        emit     = 1'b1;
                        res.kind = KIND_ENTROPY;
                    end
                end
                MODE_CODE, MODE_SCANFF:
                begin
                    if ((c_mode == MODE_SCANFF) && tok.is_stuff)
                    begin
                        // stuffed FF 00 stands for one data byte of FF
                        emit           = 1'b1;
                        res.kind       = KIND_ENTROPY;
                        res.byte_value = BYTE_PREFIX;
                        mode_next      = MODE_SCAN;
                    end
                    else
                    begin
                        emit            = 1'b1;
                        res.kind        = KIND_MARKER;
                        res.marker_code = b;
                        code_next       = b;
                        hsum_next       = '0;
                        ncomp_next      = '0;
                        mode_next       = tok.is_nolen ? MODE_PREFIX : MODE_LENHI;
                    end
                end
                default:
                begin
                    mode_next = MODE_PREFIX;
                end
            endcase
        end

        res_push = tok_take && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_PREFIX;
            code_reg   <= '0;
            len_hi_reg <= '0;
            remain_reg <= '0;
            offset_reg <= '0;
            hsum_reg   <= '0;
            ncomp_reg  <= '0;
            halted_reg <= 1'b0;
        end
        else if (tok_take)
        begin
            mode_reg   <= mode_next;
            code_reg   <= code_next;
            len_hi_reg <= len_hi_next;
            remain_reg <= remain_next;
            offset_reg <= offset_next;
            hsum_reg   <= hsum_next;
            ncomp_reg  <= ncomp_next;
            halted_reg <= halted_next;
        end
    end

endmodule

### rtl/jpeg_marker_segment_parser.sv
// JPEG marker/segment parser with entropy-data unstuffing.
// Each byte is registered in the token queue, then its result in the result queue.
// Throughput: one byte per cycle while the result queue has room.
// Reset (rst_n low, asynchronous): parser state cleared, both queues emptied.
// Depends on jmp_pkg, jmp_fifo, jmp_front and jmp_back.
module jpeg_marker_segment_parser
    import jmp_pkg::*;
#(
    parameter int TOK_DEPTH = 2,
    parameter int RES_DEPTH = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);
    tok_t      tok;
    logic      tok_empty;
    logic      tok_take;
    logic      res_full;
    logic      res_push;
    out_item_t res;

    jmp_front #(
        .DEPTH (TOK_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .tok       (tok),
        .tok_empty (tok_empty),
        .tok_take  (tok_take)
    );

    jmp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok),
        .tok_empty (tok_empty),
        .tok_take  (tok_take),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    jmp_fifo #(
        .T     (out_item_t),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    // parser never writes a result it cannot store
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into full queue");

    // a short length is always reported as the last payload byte of its segment
    a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res.error_code == ERR_LEN_SHORT)) |->
            (res.segment_last && (res.kind == KIND_PAYLOAD)))
        else $error("short-length error on malformed result");

    // only payload bytes carry an offset
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && (res.kind != KIND_PAYLOAD)) |-> (res.payload_offset == '0))
        else $error("non-payload result with nonzero offset");

endmodule
